// ===== hdl/sconv_pkg.sv =====
package sconv_pkg;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_BIAS   = 2'd2;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 40;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Round Q.20 to Q8.8 (halves toward plus infinity), then saturate.
    function automatic sample_t round_sat(input acc_t acc);
        logic signed [ACC_W:0]    v;
        logic signed [ACC_W-12:0] q;
        v = (ACC_W+1)'(acc) + (ACC_W+1)'(2048);
        q = v[ACC_W:12];
        if (q > (ACC_W-11)'(32767))
            round_sat = 16'sh7FFF;
        else if (q < -(ACC_W-11)'(32768))
            round_sat = 16'sh8000;
        else
            round_sat = SAMPLE_W'(q);
    endfunction

endpackage

// ===== hdl/streaming_conv2d_line_buffer_core.sv =====
// Streaming 2-D valid convolution, stride 1. Load weights (cmd 1) and
// biases (cmd 2) first, then stream samples (cmd 0) in raster order with
// channels interleaved. Samples shift through a chain of line-buffer cells.
// A word that does not complete a full window is accepted while idle. A word
// that completes one starts the single multiply-accumulate unit, one tap per
// cycle, for each filter in turn; a stall on the output holds it between
// filters. Input is stalled meanwhile; the output register lets the next
// word in while the final result waits.
module streaming_conv2d_line_buffer_core
#(
    parameter int IMG_WIDTH  = 28,
    parameter int IMG_HEIGHT = 28,
    parameter int CHANNELS   = 1,
    parameter int FILTERS    = 3,
    parameter int KERNEL     = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] sample,
    input  logic [9:0]         coef_index,
    input  logic signed [15:0] coef_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         filter_num,
    output logic signed [15:0] conv_value,
    output logic               last
);

    localparam int NT   = CHANNELS * KERNEL * KERNEL;
    localparam int WD   = FILTERS * NT;
    localparam int LD   = (KERNEL - 1) * IMG_WIDTH * CHANNELS + KERNEL * CHANNELS;
    localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
    localparam int LAW  = (LD > 1) ? $clog2(LD) : 1;
    localparam int CLW  = $clog2(IMG_WIDTH);
    localparam int RWW  = $clog2(IMG_HEIGHT);
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KW   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int FW   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int CNTW = $clog2(NT + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]              state_reg;
    logic [CLW-1:0]          col_reg;
    logic [RWW-1:0]          row_reg;
    logic [CHW-1:0]          chan_reg;
    logic [FW-1:0]           filt_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic [CHW-1:0]          tch_reg;
    logic [KW-1:0]           tii_reg;
    logic [KW-1:0]           tjj_reg;
    logic [WAW-1:0]          waddr_reg;
    logic                    v1_reg;
    sconv_pkg::sample_t      samp1_reg;
    sconv_pkg::sample_t      wt1_reg;
    sconv_pkg::sample_t      weight_mem [WD];
    sconv_pkg::sample_t      bias_reg [FILTERS];
    logic                    out_valid_reg;
    logic [3:0]              filter_num_reg;
    sconv_pkg::sample_t      conv_value_reg;
    logic                    last_reg;

    sconv_pkg::sample_t      cell_q [LD];
    logic                    shift_en;
    logic                    in_acc;
    logic                    fire;
    logic                    issue;
    logic [LAW-1:0]          tap_back;
    logic                    mac_load;
    sconv_pkg::sample_t      mac_bias;
    sconv_pkg::acc_t         acc;
    logic                    emit_go;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign shift_en = in_acc && (cmd == sconv_pkg::CMD_SAMPLE);
    assign fire     = shift_en && (32'(chan_reg) == CHANNELS - 1)
                      && (32'(row_reg) >= KERNEL - 1) && (32'(col_reg) >= KERNEL - 1);
    assign issue    = (state_reg == S_RUN) && (32'(cnt_reg) < NT);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    genvar gi;
    generate
        for (gi = 0; gi < LD; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sconv_cell u_cell (.clk(clk), .en(shift_en), .d(sample), .q(cell_q[gi]));
            end
            else
            begin : g_body
                sconv_cell u_cell (.clk(clk), .en(shift_en), .d(cell_q[gi-1]),
                                   .q(cell_q[gi]));
            end
        end
    endgenerate

    // Cell 0 holds the newest sample, so the tap offset is its distance back.
    always_comb
    begin
        tap_back = LAW'(((KERNEL - 1 - 32'(tii_reg)) * IMG_WIDTH
                         + (KERNEL - 1 - 32'(tjj_reg))) * CHANNELS
                        + (CHANNELS - 1 - 32'(tch_reg)));
    end

    always_comb
    begin
        mac_load = 1'b0;
        mac_bias = bias_reg[0];
        if (fire)
        begin
            mac_load = 1'b1;
        end
        else if (emit_go && (32'(filt_reg) != FILTERS - 1))
        begin
            mac_load = 1'b1;
            mac_bias = bias_reg[FW'(filt_reg + 1'b1)];
        end
    end

    sconv_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (mac_load),
        .bias  (mac_bias),
        .in_v  (v1_reg),
        .samp  (samp1_reg),
        .wt    (wt1_reg),
        .acc   (acc)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd == sconv_pkg::CMD_WEIGHT) && (32'(coef_index) < WD))
        begin
            weight_mem[WAW'(coef_index)] <= coef_value;
        end
        if (in_acc && (cmd == sconv_pkg::CMD_BIAS) && (32'(coef_index) < FILTERS))
        begin
            bias_reg[FW'(coef_index)] <= coef_value;
        end
        wt1_reg   <= weight_mem[waddr_reg];
        samp1_reg <= cell_q[tap_back];
        if (emit_go)
        begin
            filter_num_reg <= 4'(filt_reg);
            conv_value_reg <= sconv_pkg::round_sat(acc);
            last_reg       <= (32'(filt_reg) == FILTERS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= '0;
            filt_reg      <= '0;
            cnt_reg       <= '0;
            tch_reg       <= '0;
            tii_reg       <= '0;
            tjj_reg       <= '0;
            waddr_reg     <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            if (out_valid_reg && !out_stall && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            if (shift_en)
            begin
                if (32'(chan_reg) == CHANNELS - 1)
                begin
                    chan_reg <= '0;
                    if (32'(col_reg) == IMG_WIDTH - 1)
                    begin
                        col_reg <= '0;
                        if (32'(row_reg) == IMG_HEIGHT - 1)
                            row_reg <= '0;
                        else
                            row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                else
                begin
                    chan_reg <= chan_reg + 1'b1;
                end
            end
            if (issue)
            begin
                waddr_reg <= waddr_reg + 1'b1;
                if (32'(tjj_reg) == KERNEL - 1)
                begin
                    tjj_reg <= '0;
                    if (32'(tii_reg) == KERNEL - 1)
                    begin
                        tii_reg <= '0;
                        if (32'(tch_reg) == CHANNELS - 1)
                            tch_reg <= '0;
                        else
                            tch_reg <= tch_reg + 1'b1;
                    end
                    else
                    begin
                        tii_reg <= tii_reg + 1'b1;
                    end
                end
                else
                begin
                    tjj_reg <= tjj_reg + 1'b1;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (fire)
                    begin
                        state_reg <= S_RUN;
                        filt_reg  <= '0;
                        cnt_reg   <= '0;
                        waddr_reg <= '0;
                        tch_reg   <= '0;
                        tii_reg   <= '0;
                        tjj_reg   <= '0;
                    end
                end
                S_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    // the last product lands in the accumulator at this edge
                    if (32'(cnt_reg) == NT + 1)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        if (32'(filt_reg) == FILTERS - 1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            filt_reg  <= filt_reg + 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= S_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign filter_num = filter_num_reg;
    assign conv_value = conv_value_reg;
    assign last       = last_reg;

`ifndef ASSERT_OFF
    a_fire_runs: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (state_reg == S_RUN && cnt_reg == '0))
        else $error("window fire did not start the accumulation");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (32'(cnt_reg) <= NT + 1))
        else $error("tap counter overran");
    a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (32'(filter_num) == FILTERS - 1))
        else $error("last flag on a filter other than the final one");
    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RUN) |-> !issue)
        else $error("tap issued outside accumulation");
`endif

endmodule

// ===== hdl/sconv_cell.sv =====
module sconv_cell
(
    input  logic                clk,
    input  logic                en,
    input  sconv_pkg::sample_t  d,
    output sconv_pkg::sample_t  q
);

    sconv_pkg::sample_t q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== hdl/sconv_mac.sv =====
module sconv_mac
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sconv_pkg::sample_t  bias,
    input  logic                in_v,
    input  sconv_pkg::sample_t  samp,
    input  sconv_pkg::sample_t  wt,
    output sconv_pkg::acc_t     acc
);

    logic signed [31:0] prod_reg;
    logic               pv_reg;
    sconv_pkg::acc_t    acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= samp * wt;
        if (load)
        begin
            acc_reg <= sconv_pkg::ACC_W'(bias) <<< 12;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + sconv_pkg::ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== dv/streaming_conv2d_line_buffer_core_tb.sv =====
module streaming_conv2d_line_buffer_core_tb;

    localparam int IMG_W   = 28;
    localparam int IMG_H   = 28;
    localparam int NCH     = 1;
    localparam int NFILT   = 3;
    localparam int KSIZE   = 3;
    localparam int NTAPS   = KSIZE * KSIZE;
    localparam int NWEIGHT = NFILT * NCH * NTAPS;
    localparam int RING    = (KSIZE - 1) * IMG_W * NCH + KSIZE * NCH;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]   filt;
        logic [15:0]  value;
        logic         last_flag;
    } conv_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = sconv_pkg::CMD_SAMPLE;
    logic signed [15:0] sample = '0;
    logic [9:0] coef_index = '0;
    logic signed [15:0] coef_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] filter_num;
    logic signed [15:0] conv_value;
    logic last;

    sconv_pkg::sample_t ring_mem [RING];
    sconv_pkg::sample_t weight_mem [NWEIGHT];
    sconv_pkg::sample_t bias_mem [NFILT];
    int           col_pos, row_pos, ch_pos, ring_wr;
    conv_result_t pending_results [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    streaming_conv2d_line_buffer_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .sample(sample), .coef_index(coef_index),
        .coef_value(coef_value), .out_valid(out_valid), .out_stall(out_stall),
        .filter_num(filter_num), .conv_value(conv_value), .last(last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic sconv_pkg::sample_t window_result(input int filt);
        sconv_pkg::acc_t                  acc;
        logic signed [sconv_pkg::ACC_W:0]    v;
        logic signed [sconv_pkg::ACC_W-12:0] q;
        int back, slot, widx;
        acc = sconv_pkg::acc_t'(bias_mem[filt]) <<< 12;
        for (int c = 0; c < NCH; c++)
            for (int i = 0; i < KSIZE; i++)
                for (int j = 0; j < KSIZE; j++)
                begin
                    back = ((KSIZE - 1 - i) * IMG_W + (KSIZE - 1 - j)) * NCH + (NCH - 1 - c);
                    slot = (ring_wr + RING - 1 - back) % RING;
                    widx = filt * NCH * NTAPS + c * NTAPS + i * KSIZE + j;
                    acc = acc + sconv_pkg::acc_t'(ring_mem[slot])
                              * sconv_pkg::acc_t'(weight_mem[widx]);
                end
        v = {acc[sconv_pkg::ACC_W-1], acc} + (sconv_pkg::ACC_W+1)'(2048);
        q = v[sconv_pkg::ACC_W:12];
        if (q > 32767)
            return 16'sh7FFF;
        if (q < -32768)
            return 16'sh8000;
        return q[15:0];
    endfunction

    task automatic predict_word(input logic [1:0] c, input logic [15:0] s,
                                input logic [9:0] idx, input logic [15:0] val);
        conv_result_t r;
        if (c == sconv_pkg::CMD_WEIGHT)
        begin
            if (idx < NWEIGHT)
                weight_mem[idx] = val;
        end
        else if (c == sconv_pkg::CMD_BIAS)
        begin
            if (idx < NFILT)
                bias_mem[idx] = val;
        end
        else if (c == sconv_pkg::CMD_SAMPLE)
        begin
            ring_mem[ring_wr] = s;
            ring_wr = (ring_wr + 1) % RING;
            if (ch_pos == NCH - 1 && row_pos >= KSIZE - 1 && col_pos >= KSIZE - 1)
                for (int f = 0; f < NFILT; f++)
                begin
                    r.filt = 4'(f);
                    r.value = window_result(f);
                    r.last_flag = (f == NFILT - 1);
                    pending_results.push_back(r);
                end
            ch_pos++;
            if (ch_pos >= NCH)
            begin
                ch_pos = 0;
                col_pos++;
                if (col_pos >= IMG_W)
                begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= IMG_H)
                        row_pos = 0;
                end
            end
        end
    endtask

    // Send one word; hold it until accepted.
    task automatic send_word(input logic [1:0] c, input logic [15:0] s,
                             input logic [9:0] idx, input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        sample <= s;
        coef_index <= idx;
        coef_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(c, s, idx, val);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        conv_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result filter %0d value %0d", filter_num, conv_value);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (filter_num !== exp_r.filt || conv_value !== exp_r.value
                    || last !== exp_r.last_flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp f=%0d v=%0d l=%0d got f=%0d v=%0d l=%0d",
                                 exp_r.filt, $signed(exp_r.value), exp_r.last_flag,
                                 filter_num, conv_value, last);
                end
            end
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic load_coefs(input int mode);
        logic [15:0] v;
        for (int i = 0; i < NWEIGHT; i++)
        begin
            case (mode)
                0: v = 16'h1000;
                1: v = (i % 2) ? 16'h7FFF : 16'h8000;
                default: v = 16'($urandom_range(16'hFFFF));
            endcase
            send_word(sconv_pkg::CMD_WEIGHT, 16'($urandom_range(16'hFFFF)), 10'(i), v);
        end
        for (int f = 0; f < NFILT; f++)
        begin
            case (mode)
                0: v = 16'h0000;
                1: v = (f == 0) ? 16'h7FFF : 16'h8000;
                default: v = 16'($urandom_range(16'hFFFF));
            endcase
            send_word(sconv_pkg::CMD_BIAS, 16'($urandom_range(16'hFFFF)), 10'(f), v);
        end
    endtask

    // Ignored words: out-of-range indexes and the unused command.
    task automatic test_ignored_words();
        send_word(sconv_pkg::CMD_WEIGHT, 16'h0, 10'(NWEIGHT), 16'h7FFF);
        send_word(sconv_pkg::CMD_WEIGHT, 16'h0, 10'h3FF, 16'h8000);
        send_word(sconv_pkg::CMD_BIAS, 16'h0, 10'(NFILT), 16'h7FFF);
        send_word(sconv_pkg::CMD_BIAS, 16'h0, 10'h3FF, 16'h8000);
        send_word(CMD_UNUSED, 16'h7FFF, 10'h3FF, 16'hFFFF);
        send_word(CMD_UNUSED, 16'h8000, 10'h000, 16'h0000);
    endtask

    // Stream image samples; extreme values in turn when asked, else random.
    task automatic test_image_samples(input int count, input bit extremes);
        logic [15:0] s;
        for (int n = 0; n < count; n++)
        begin
            if (extremes)
                case (n % 4)
                    0: s = 16'h7FFF;
                    1: s = 16'h8000;
                    2: s = 16'h0000;
                    default: s = 16'hFFFF;
                endcase
            else
                s = 16'($urandom_range(16'hFFFF));
            if ($urandom_range(19) == 0)
                send_word($urandom_range(1) ? CMD_UNUSED : sconv_pkg::CMD_WEIGHT,
                          16'($urandom_range(16'hFFFF)),
                          10'(NWEIGHT + $urandom_range(900)),
                          16'($urandom_range(16'hFFFF)));
            send_word(sconv_pkg::CMD_SAMPLE, s, 10'($urandom_range(10'h3FF)),
                      16'($urandom_range(16'hFFFF)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 45;
        load_coefs(1);
        test_ignored_words();
        test_image_samples(70, 1'b1);
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 33;
        load_coefs(2);
        test_image_samples(20, 1'b0);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_coefs(0);
        test_image_samples(20, 1'b0);
        wait_drained();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== streaming_conv2d_line_buffer_core.f =====
hdl/sconv_pkg.sv
hdl/sconv_cell.sv
hdl/sconv_mac.sv
hdl/streaming_conv2d_line_buffer_core.sv
dv/streaming_conv2d_line_buffer_core_tb.sv
